/* design/fstg_pkg.sv */
// ----------------------------------------------------------------------------
// fstg_pkg
// Shared types and constants for the foot swing trajectory generator.
// ----------------------------------------------------------------------------
package fstg_pkg;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic CFG_MOVE_SPEED  = 1'b0;
    localparam logic CFG_LIFT_HEIGHT = 1'b1;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LIFT   = 2'd1;
    localparam logic [1:0] PH_ACROSS = 2'd2;
    localparam logic [1:0] PH_LOWER  = 2'd3;

    localparam int unsigned SPEED_MIN = 66;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD_START,   // latch points, speed, lift; select lift segment
        CMD_SEG_ACROSS,   // select segment end -> goal + lift
        CMD_SEG_LOWER,    // select segment end -> goal
        CMD_DIST,         // sum L1 distance
        CMD_DUR_INIT,     // start duration divide
        CMD_DUR_STEP,     // one divider bit
        CMD_DUR_FIX,      // clamp duration
        CMD_VEL_INIT,     // start velocity divide for current axis
        CMD_VEL_STEP,
        CMD_VEL_FIX,
        CMD_TICK,         // advance elapsed
        CMD_INTERP,       // one axis of interpolation
        CMD_OUT_START,
        CMD_OUT_IDLE,
        CMD_OUT_END
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [1:0] axis;
    } ctl_t;

    typedef struct packed {
        logic div_done;
        logic seg_over;
    } sts_t;

endpackage

/* design/fstg_datapath.sv */
// ----------------------------------------------------------------------------
// fstg_datapath
// Segment state, a shared restoring divider, the interpolation multiplier.
// ----------------------------------------------------------------------------
module fstg_datapath #(
    parameter int TIME_BITS = 24,
    parameter int POS_BITS  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fstg_pkg::ctl_t        ctl,
    output fstg_pkg::sts_t        sts,
    input  logic [31:0]           move_speed,
    input  logic signed [15:0]    lift_height,
    input  logic [191:0]          in_pts,
    output logic signed [31:0]    out_x,
    output logic signed [31:0]    out_y,
    output logic signed [31:0]    out_z
);
    localparam int PW = POS_BITS + 2;           // delta width
    localparam int DW = PW + 12;                // dist*1000 width
    localparam int NW = 64;                     // divider numerator width
    localparam int CW = $clog2(NW + 1);
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
    localparam logic [47:0] VMAX = {1'b0, {47{1'b1}}};
    // any offset at or above this saturates the position anyway
    localparam logic [62:0] OFF_CAP = 63'(1) << (POS_BITS + 1);

    function automatic logic signed [POS_BITS-1:0] satp(input logic signed [PW:0] v);
        logic signed [PW:0] hi;
        logic signed [PW:0] lo;
        hi = (PW+1)'({1'b0, {(POS_BITS-1){1'b1}}});
        lo = -hi - (PW+1)'(1);
        if (v > hi) return hi[POS_BITS-1:0];
        if (v < lo) return lo[POS_BITS-1:0];
        return v[POS_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [POS_BITS-1:0] v);
        logic signed [PW:0] w;
        w = (PW+1)'(v);
        if (w > (PW+1)'(33'sh7FFFFFFF)) return 32'sh7FFFFFFF;
        if (w < -(PW+1)'(33'sh80000000)) return 32'sh80000000;
        return w[31:0];
    endfunction

    logic signed [POS_BITS-1:0] st_reg [3];
    logic signed [POS_BITS-1:0] en_reg [3];
    logic signed [POS_BITS-1:0] goal_reg [3];
    logic signed [POS_BITS-1:0] last_reg [3];
    logic signed [47:0]         vel_reg [3];
    logic signed [PW:0]         lift_reg;
    logic [31:0]                spd_reg;
    logic [TIME_BITS-1:0]       el_reg;
    logic [TIME_BITS-1:0]       ms_reg;
    logic [DW-1:0]              dist_reg;
    logic [NW-1:0]              num_reg;
    logic [NW-1:0]              quo_reg;
    logic [NW:0]                rem_reg;
    logic [NW-1:0]              den_reg;
    logic [CW-1:0]              cnt_reg;
    logic [97:0]                prod_reg;
    logic signed [POS_BITS-1:0] pend_reg [3];

    logic [1:0]        ax;
    logic signed [PW:0] dlt;
    logic [PW:0]        dmag;
    logic [NW:0]        rtry;
    logic [NW-1:0]      qsat;
    logic [62:0]        off;
    logic [62:0]        offc;
    logic signed [PW+1:0] isum;
    assign ax = ctl.axis;

    always_comb
    begin
        dlt  = (PW+1)'(en_reg[ax]) - (PW+1)'(st_reg[ax]);
        dmag = dlt[PW] ? -dlt : dlt;
        rtry = {rem_reg[NW-1:0], num_reg[NW-1]} - {1'b0, den_reg};
        off  = prod_reg[97:16] > 82'(63'h4000000000000000)
               ? 63'h4000000000000000 : prod_reg[78:16];
        offc = (off > OFF_CAP) ? OFF_CAP : off;
        if (vel_reg[ax][47])
            isum = (PW+2)'(st_reg[ax]) - $signed((PW+2)'(offc));
        else
            isum = (PW+2)'(st_reg[ax]) + $signed((PW+2)'(offc));
        qsat = quo_reg;
    end

    logic [47:0] vmag;
    logic [47:0] velabs;
    always_comb
    begin
        vmag   = vel_reg[ax][47] ? -vel_reg[ax] : vel_reg[ax];
        velabs = (qsat > 64'(VMAX)) ? VMAX : qsat[47:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                st_reg[i] <= '0; en_reg[i] <= '0; goal_reg[i] <= '0;
                last_reg[i] <= '0; vel_reg[i] <= '0; pend_reg[i] <= '0;
            end
            lift_reg <= '0; spd_reg <= 32'd65536;
            el_reg <= '0; ms_reg <= TIME_BITS'(1);
            dist_reg <= '0; num_reg <= '0; quo_reg <= '0; rem_reg <= '0;
            den_reg <= '0; cnt_reg <= '0; prod_reg <= '0;
        end
        else
        begin
            unique case (ctl.cmd)
                fstg_pkg::CMD_LOAD_START:
                begin
                    spd_reg  <= move_speed < 32'(fstg_pkg::SPEED_MIN)
                                ? 32'(fstg_pkg::SPEED_MIN) : move_speed;
                    lift_reg <= (PW+1)'($signed({lift_height, 16'h0000}));
                    for (int i = 0; i < 3; i++)
                    begin
                        st_reg[i]   <= satp((PW+1)'($signed(in_pts[32*i +: 32])));
                        goal_reg[i] <= satp((PW+1)'($signed(in_pts[96+32*i +: 32])));
                        if (i == 2)
                            en_reg[i] <= satp((PW+1)'(satp((PW+1)'($signed(in_pts[64 +: 32]))))
                                              + (PW+1)'($signed({lift_height, 16'h0000})));
                        else
                            en_reg[i] <= satp((PW+1)'($signed(in_pts[32*i +: 32])));
                    end
                    dist_reg <= '0;
                    el_reg   <= '0;
                end
                fstg_pkg::CMD_SEG_ACROSS:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        st_reg[i] <= en_reg[i];
                        if (i == 2)
                            en_reg[i] <= satp((PW+1)'(goal_reg[2]) + lift_reg);
                        else
                            en_reg[i] <= goal_reg[i];
                    end
                    dist_reg <= '0; el_reg <= '0;
                end
                fstg_pkg::CMD_SEG_LOWER:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        st_reg[i] <= en_reg[i];
                        en_reg[i] <= goal_reg[i];
                    end
                    dist_reg <= '0; el_reg <= '0;
                end
                fstg_pkg::CMD_DIST:
                    dist_reg <= dist_reg + DW'(dmag);
                fstg_pkg::CMD_DUR_INIT:
                begin
                    num_reg <= NW'(dist_reg) * NW'(1000);
                    den_reg <= NW'(spd_reg);
                    rem_reg <= '0; quo_reg <= '0; cnt_reg <= CW'(NW);
                end
                fstg_pkg::CMD_VEL_INIT:
                begin
                    // magnitude * 65536 / duration
                    num_reg <= NW'(dmag) << 16;
                    den_reg <= NW'(ms_reg);
                    rem_reg <= '0; quo_reg <= '0; cnt_reg <= CW'(NW);
                end
                fstg_pkg::CMD_DUR_STEP, fstg_pkg::CMD_VEL_STEP:
                begin
                    num_reg <= num_reg << 1;
                    if (!rtry[NW])
                    begin
                        rem_reg <= rtry;
                        quo_reg <= {quo_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[NW-1:0], num_reg[NW-1]};
                        quo_reg <= {quo_reg[NW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CW'(1);
                end
                fstg_pkg::CMD_DUR_FIX:
                    ms_reg <= (qsat == '0) ? TIME_BITS'(1)
                            : (qsat > NW'(TMAX)) ? TMAX : qsat[TIME_BITS-1:0];
                fstg_pkg::CMD_VEL_FIX:
                    vel_reg[ax] <= dlt[PW] ? -$signed(velabs) : $signed(velabs);
                fstg_pkg::CMD_TICK:
                begin
                    if (el_reg != TMAX)
                        el_reg <= el_reg + TIME_BITS'(1);
                    prod_reg <= '0;
                end
                fstg_pkg::CMD_INTERP:
                    prod_reg <= 98'(vmag) * 98'(el_reg);
                fstg_pkg::CMD_OUT_START:
                    for (int i = 0; i < 3; i++) last_reg[i] <= st_reg[i];
                fstg_pkg::CMD_OUT_END:
                    for (int i = 0; i < 3; i++) last_reg[i] <= pend_reg[i];
                fstg_pkg::CMD_OUT_IDLE:
                    pend_reg[ax] <= satp(isum[PW:0]);
                default: ;
            endcase
        end
    end

    assign sts.div_done = (cnt_reg == '0);
    assign sts.seg_over = (el_reg >= ms_reg);
    assign out_x = sat32(last_reg[0]);
    assign out_y = sat32(last_reg[1]);
    assign out_z = sat32(last_reg[2]);
endmodule

/* design/fstg_ctrl.sv */
// ----------------------------------------------------------------------------
// fstg_ctrl
// Sequencer for segment set-up, ticks and interpolation.
// ----------------------------------------------------------------------------
module fstg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_go,
    input  logic           item_op,
    input  fstg_pkg::sts_t sts,
    output fstg_pkg::ctl_t ctl,
    output logic           busy,
    output logic           res_go,
    output logic [1:0]     phase
);
    typedef enum logic [3:0] {
        S_IDLE, S_DIST, S_DINIT, S_DSTEP, S_DFIX, S_VINIT, S_VSTEP, S_VFIX,
        S_TCHK, S_MUL, S_ACC, S_COMMIT, S_OUT, S_END
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      axis_reg, axis_next;
    logic [1:0]      ph_reg, ph_next;
    logic            emit_reg, emit_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        ph_next    = ph_reg;
        emit_next  = 1'b0;
        ctl.cmd    = fstg_pkg::CMD_NONE;
        ctl.axis   = axis_reg;
        unique case (state_reg)
            S_IDLE:
                if (item_go)
                begin
                    if (item_op == fstg_pkg::OP_START)
                    begin
                        ctl.cmd = fstg_pkg::CMD_LOAD_START;
                        ph_next = fstg_pkg::PH_LIFT;
                        axis_next = 2'd0;
                        state_next = S_DIST;
                    end
                    else if (ph_reg == fstg_pkg::PH_IDLE)
                        emit_next = 1'b1;
                    else
                    begin
                        ctl.cmd = fstg_pkg::CMD_TICK;
                        state_next = S_TCHK;
                    end
                end
            S_DIST:
            begin
                ctl.cmd = fstg_pkg::CMD_DIST;
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                    state_next = S_DINIT;
            end
            S_DINIT: begin ctl.cmd = fstg_pkg::CMD_DUR_INIT; state_next = S_DSTEP; end
            S_DSTEP:
                if (sts.div_done) state_next = S_DFIX;
                else ctl.cmd = fstg_pkg::CMD_DUR_STEP;
            S_DFIX:
            begin
                ctl.cmd = fstg_pkg::CMD_DUR_FIX;
                axis_next = 2'd0;
                state_next = S_VINIT;
            end
            S_VINIT: begin ctl.cmd = fstg_pkg::CMD_VEL_INIT; state_next = S_VSTEP; end
            S_VSTEP:
                if (sts.div_done) state_next = S_VFIX;
                else ctl.cmd = fstg_pkg::CMD_VEL_STEP;
            S_VFIX:
            begin
                ctl.cmd = fstg_pkg::CMD_VEL_FIX;
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                    state_next = S_OUT;
                else
                    state_next = S_VINIT;
            end
            S_TCHK:
            begin
                axis_next = 2'd0;
                if (sts.seg_over)
                begin
                    // segment end reached: pick the next phase, shift in S_COMMIT
                    unique case (ph_reg)
                        fstg_pkg::PH_LIFT:   ph_next = fstg_pkg::PH_ACROSS;
                        fstg_pkg::PH_ACROSS: ph_next = fstg_pkg::PH_LOWER;
                        default:             ph_next = fstg_pkg::PH_IDLE;
                    endcase
                    state_next = S_COMMIT;
                end
                else
                    state_next = S_MUL;
            end
            S_COMMIT:
            begin
                // shift segment; the new start is the old end, which is the output
                unique case (ph_reg)
                    fstg_pkg::PH_ACROSS:
                    begin
                        ctl.cmd = fstg_pkg::CMD_SEG_ACROSS;
                        state_next = S_DIST;
                    end
                    fstg_pkg::PH_LOWER:
                    begin
                        ctl.cmd = fstg_pkg::CMD_SEG_LOWER;
                        state_next = S_DIST;
                    end
                    default:
                    begin
                        ctl.cmd = fstg_pkg::CMD_SEG_LOWER;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                // present the segment start
                ctl.cmd = fstg_pkg::CMD_OUT_START;
                state_next = S_IDLE;
                emit_next = 1'b1;
            end
            S_MUL: begin ctl.cmd = fstg_pkg::CMD_INTERP; state_next = S_ACC; end
            S_ACC:
            begin
                ctl.cmd = fstg_pkg::CMD_OUT_IDLE;
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                    state_next = S_END;
                else
                    state_next = S_MUL;
            end
            S_END:
            begin
                // present the interpolated point
                ctl.cmd = fstg_pkg::CMD_OUT_END;
                state_next = S_IDLE;
                emit_next = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
            ph_reg    <= fstg_pkg::PH_IDLE;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            ph_reg    <= ph_next;
            emit_reg  <= emit_next;
        end
    end

    assign busy   = (state_reg != S_IDLE) || emit_reg;
    assign res_go = emit_reg;
    assign phase  = ph_reg;
endmodule

/* design/foot_swing_trajectory_generator.sv */
// ----------------------------------------------------------------------------
// foot_swing_trajectory_generator
// Three-segment linear foot swing (lift, across, lower) in Q16.16.
// ----------------------------------------------------------------------------
//  channel  | dir | content
//  s_axis   | in  | tdata: start_x..goal_z (192b), tuser: opcode
//  m_axis   | out | tdata: pos_x,pos_y,pos_z,phase,done_res (104b)
//  cfg      | in  | cfg_we/cfg_addr/cfg_wdata, index 0 speed, 1 lift
//
// Steps between the accepting edge and a valid result beat: a tick inside a
// segment runs three multiply/accumulate pairs and a copy; a start and a tick
// that changes segment run a bit-serial divider over a 64-bit numerator four
// times (duration, then one per axis); the tick that ends the lowering only
// shifts the segment and copies its start; a tick while idle runs no step.
// Reset clears phase to idle and the position to zero. The input is taken
// only when no item is in flight and the output register is empty, so a
// stalled result beat holds off the next input beat.
// ----------------------------------------------------------------------------
module foot_swing_trajectory_generator #(
    parameter int TIME_BITS = 24,
    parameter int POS_BITS  = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // start_x,start_y,start_z,goal_x,goal_y,goal_z
    input  logic         s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // pos_x,pos_y,pos_z,phase,done_res,pad
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    fstg_pkg::ctl_t ctl;
    fstg_pkg::sts_t sts;
    logic [31:0]        speed_reg;
    logic signed [15:0] lift_reg;
    logic               busy, res_go, item_go, out_v_reg;
    logic [1:0]         phase;
    logic signed [31:0] px, py, pz;

    // Accept a beat only with the pipe empty
    assign s_axis_tready = !busy && !out_v_reg;
    assign item_go = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 32'd65536;
            lift_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_addr == fstg_pkg::CFG_MOVE_SPEED) speed_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == fstg_pkg::CFG_LIFT_HEIGHT) lift_reg <= cfg_wdata[15:0];
            // hold the result beat until taken
            if (res_go) out_v_reg <= 1'b1;
            else if (m_axis_tready) out_v_reg <= 1'b0;
        end
    end

    fstg_datapath #(.TIME_BITS(TIME_BITS), .POS_BITS(POS_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .move_speed(speed_reg), .lift_height(lift_reg), .in_pts(s_axis_tdata),
        .out_x(px), .out_y(py), .out_z(pz)
    );

    fstg_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .item_go(item_go), .item_op(s_axis_tuser),
        .sts(sts), .ctl(ctl), .busy(busy), .res_go(res_go), .phase(phase)
    );

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {5'd0, (phase == fstg_pkg::PH_IDLE), phase, pz, py, px};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_go |=> !s_axis_tready) else $error("accepted while busy");
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[98] == (m_axis_tdata[97:96] == fstg_pkg::PH_IDLE)))
        else $error("done flag mismatch");
`endif
endmodule
